@@ src/rlsu_pkg.sv @@
package rlsu_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_REVERSE = 2'd2
  } func_e;

  typedef struct packed {
    logic load;
    logic step;
  } ptr_cmd_t;

endpackage

@@ src/rlsu_mem.sv @@
module rlsu_mem #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rlsu_ptr.sv @@
module rlsu_ptr #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlsu_pkg::ptr_cmd_t cmd_i,
  input  logic [AW-1:0]     last_i,
  output logic [AW-1:0]     lo_o,
  output logic [AW-1:0]     hi_o,
  output logic              more_o
);

  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = last_i;
    end else if (cmd_i.step) begin
      lo_d = lo_q + AW'(1);
      hi_d = hi_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Another swap follows the current one when lo + 1 < hi - 1.
  assign more_o = ({1'b0, lo_q} + (AW + 1)'(2)) < {1'b0, hi_q};
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;

endmodule

@@ src/reversible_lifo_stack_unit.sv @@
// Bounded LIFO stack of signed words with push, pop and in-place reverse.
// The slave stream carries one operation per transaction: tuser selects the
// operation (push, pop, reverse) and tdata holds the word for a push. Every
// accepted transaction yields exactly one master-stream transaction with the
// new top word (zero when empty), a top-valid flag, the fill level and a flag
// that marks a push rejected because the stack was full. Pops on an empty
// stack and unused operation codes leave the stack unchanged.
// A push, an ignored operation or a pop that empties the stack goes straight
// to the result; any other pop first reads the new top word from the entry
// memory; a reverse of N >= 2 entries walks each swap through read low, read
// high, write low and write high, then reads the new top word, as the entry
// memory has a single read port. The block takes one operation at a time;
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register, so a new operation is taken while the previous result
// still waits; if the receiver has not taken it by the time the next result
// is ready, the sequencer holds that result until the register frees.
// Reset empties the stack at once; memory contents are not cleared and are
// never read before being written.
module reversible_lifo_stack_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1),
  localparam int unsigned IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // push_value
  input  logic [1:0]       s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // top_value, fill_level
  output logic [1:0]       m_axis_tuser    // top_valid, push_dropped
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RLO  = 8'b0000_0010,
    S_RHI  = 8'b0000_0100,
    S_WLO  = 8'b0000_1000,
    S_WHI  = 8'b0001_0000,
    S_TRD  = 8'b0010_0000,
    S_TLAT = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  logic                  drop_q, drop_d;
  logic [DATA_WIDTH-1:0] hold_q, hold_d;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_top_q, out_top_d;
  logic [CW-1:0]         out_fill_q, out_fill_d;
  logic                  out_drop_q, out_drop_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  rlsu_pkg::ptr_cmd_t ptr_cmd;
  logic [AW-1:0]      ptr_lo;
  logic [AW-1:0]      ptr_hi;
  logic               ptr_more;

  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         cnt_m2;
  logic [DATA_WIDTH-1:0] push_value;
  rlsu_pkg::func_e       func;
  logic                  in_accept;

  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign push_value = s_axis_tdata[DATA_WIDTH-1:0];
  assign func       = rlsu_pkg::func_e'(s_axis_tuser);
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  rlsu_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rlsu_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ptr_cmd),
    .last_i (cnt_m1[AW-1:0]),
    .lo_o   (ptr_lo),
    .hi_o   (ptr_hi),
    .more_o (ptr_more)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    drop_d      = drop_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q;
    out_top_d   = out_top_q;
    out_fill_d  = out_fill_q;
    out_drop_d  = out_drop_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = push_value;
    mem_raddr   = cnt_m1[AW-1:0];
    ptr_cmd     = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          drop_d  = 1'b0;
          state_d = S_EMIT;
          case (func)
            rlsu_pkg::FUNC_PUSH: begin
              if (count_q < CW'(DEPTH)) begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                top_d   = push_value;
              end else begin
                drop_d = 1'b1;
              end
            end
            rlsu_pkg::FUNC_POP: begin
              if (count_q != '0) begin
                count_d = cnt_m1;
                if (count_q == CW'(1)) begin
                  top_d = '0;
                end else begin
                  mem_raddr = cnt_m2[AW-1:0];
                  state_d   = S_TLAT;
                end
              end
            end
            rlsu_pkg::FUNC_REVERSE: begin
              if (count_q >= CW'(2)) begin
                ptr_cmd.load = 1'b1;
                state_d      = S_RLO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RLO: begin
        mem_raddr = ptr_lo;
        state_d   = S_RHI;
      end
      S_RHI: begin
        mem_raddr = ptr_hi;
        hold_d    = mem_rdata;
        state_d   = S_WLO;
      end
      S_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_lo;
        mem_wdata = mem_rdata;
        state_d   = S_WHI;
      end
      S_WHI: begin
        mem_we       = 1'b1;
        mem_waddr    = ptr_hi;
        mem_wdata    = hold_q;
        ptr_cmd.step = 1'b1;
        state_d      = ptr_more ? S_RLO : S_TRD;
      end
      S_TRD: begin
        mem_raddr = cnt_m1[AW-1:0];
        state_d   = S_TLAT;
      end
      S_TLAT: begin
        top_d   = mem_rdata;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_top_d   = (count_q != '0) ? top_q : '0;
          out_fill_d  = count_q;
          out_drop_d  = drop_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    hold_q     <= hold_d;
    out_top_q  <= out_top_d;
    out_fill_q <= out_fill_d;
    out_drop_q <= out_drop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_fill_q, out_top_q});
  assign m_axis_tuser  = {out_drop_q, (out_fill_q != '0)};

endmodule

@@ tb/tb_reversible_lifo_stack_unit.sv @@
`timescale 1ns / 100ps

module tb_reversible_lifo_stack_unit;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CW         = 7;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned OUT_W      = 40;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          RANDOM_OPS  = 1150;
  localparam int          LIMIT       = 1000000;
  localparam int          DRAIN_WAIT  = 300;
  localparam int          PAUSE_AT    = 700;
  localparam int          HOLD_AT     = 400;
  localparam int          HOLD_LEN    = 400;

  typedef struct packed {
    logic [1:0]            func;
    logic [DATA_WIDTH-1:0] value;
  } stack_op_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] top_value;
    logic                  top_valid;
    logic [CW-1:0]         fill_level;
    logic                  push_dropped;
  } stack_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [IN_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = rlsu_pkg::FUNC_PUSH;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  stack_op_t     pending_ops[$];
  stack_status_t status_q[$];

  logic [DATA_WIDTH-1:0] model_store [DEPTH];
  int model_count = 0;
  int gen_count = 0;

  int cycle_cnt = 0;
  int sent_cnt = 0;
  int total_ops = 0;
  int recv_cnt = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int burst_left = 4;
  int hold_left = 0;
  bit pause_done = 1'b0;
  bit hold_done = 1'b0;

  int n_push = 0;
  int n_pop = 0;
  int n_rev = 0;
  int n_drop = 0;
  int n_ignored = 0;
  int n_full_rev = 0;

  reversible_lifo_stack_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // push_value
    .s_axis_tuser  (s_tuser),   // func
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // top_value, fill_level
    .m_axis_tuser  (m_tuser)    // top_valid, push_dropped
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Queue an operation and track the fill level it leads to, so that the
  // random sequences can aim at the full and empty boundaries.
  function automatic bit queue_op(logic [1:0] func, logic [DATA_WIDTH-1:0] value);
    stack_op_t op;
    bit effective;
    op.func = func;
    op.value = value;
    pending_ops.insert(pending_ops.size(), op);
    effective = 1'b1;
    if (func == rlsu_pkg::FUNC_PUSH) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (func == rlsu_pkg::FUNC_POP) begin
      if (gen_count > 0) gen_count--;
      else effective = 1'b0;
    end else if (func == FUNC_UNUSED) begin
      effective = 1'b0;
    end
    return effective;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: rand_word = 32'h8000_0000;
      1: rand_word = 32'h7FFF_FFFF;
      2: rand_word = 32'hFFFF_FFFF;
      3: rand_word = 32'h0000_0000;
      default: rand_word = $urandom();
    endcase
  endfunction

  // Applies one accepted operation to the stack model and records the status
  // the block must report for it.
  task automatic apply_stack_op(stack_op_t op);
    stack_status_t st;
    logic [DATA_WIDTH-1:0] tmp;
    int lo;
    int hi;
    st.push_dropped = 1'b0;
    case (op.func)
      rlsu_pkg::FUNC_PUSH: begin
        n_push++;
        if (model_count < DEPTH) begin
          model_store[model_count] = op.value;
          model_count++;
        end else begin
          st.push_dropped = 1'b1;
          n_drop++;
        end
      end
      rlsu_pkg::FUNC_POP: begin
        if (model_count > 0) begin
          model_count--;
          n_pop++;
        end else begin
          n_ignored++;
        end
      end
      rlsu_pkg::FUNC_REVERSE: begin
        n_rev++;
        if (model_count == DEPTH) n_full_rev++;
        lo = 0;
        hi = model_count - 1;
        while (lo < hi) begin
          tmp = model_store[lo];
          model_store[lo] = model_store[hi];
          model_store[hi] = tmp;
          lo++;
          hi--;
        end
      end
      default: n_ignored++;
    endcase
    st.top_valid = (model_count > 0);
    st.top_value = (model_count > 0) ? model_store[model_count-1] : '0;
    st.fill_level = model_count[CW-1:0];
    status_q.insert(status_q.size(), st);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Sender: bursts with random gaps, one pause until all results are back.
  always @(posedge clk_i) begin
    stack_op_t op;
    bit offer;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        op = pending_ops.pop_front();
        apply_stack_op(op);
        sent_cnt++;
      end
      if (s_tvalid && !s_tready) begin
        offer = 1'b1;
      end else if (pending_ops.size() == 0) begin
        offer = 1'b0;
      end else if (sent_cnt == PAUSE_AT && !pause_done) begin
        offer = 1'b0;
        if (status_q.size() == 0) pause_done = 1'b1;
      end else if (gap_left > 0) begin
        offer = 1'b0;
        gap_left--;
      end else begin
        offer = 1'b1;
        s_tdata <= pending_ops[0].value;
        s_tuser <= pending_ops[0].func;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      s_tvalid <= offer;
    end
  end

  // Receiver: always ready early in each window of cycle_cnt modulo 64, random stalls in the rest, one long hold.
  always @(posedge clk_i) begin
    stack_status_t exp_st;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        recv_cnt++;
        if (status_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual %0h/%0h",
                   $time, m_tdata, m_tuser);
        end else begin
          exp_st = status_q.pop_front();
          check_field("top_value", 64'(exp_st.top_value),
                      64'(m_tdata[DATA_WIDTH-1:0]));
          check_field("fill_level", 64'(exp_st.fill_level),
                      64'(m_tdata[DATA_WIDTH+CW-1:DATA_WIDTH]));
          check_field("top_valid", 64'(exp_st.top_valid), 64'(m_tuser[0]));
          check_field("push_dropped", 64'(exp_st.push_dropped), 64'(m_tuser[1]));
        end
      end
      if (recv_cnt == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if ((cycle_cnt % 64) < 20) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, status_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int mode;
    int seg_len;
    int extra;
    int counted;
    bit eff;

    // Boundary words, reverse of several, one and zero entries, pops and
    // unused codes on an empty stack.
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'h8000_0000));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'h7FFF_FFFF));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'h0000_0000));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'hFFFF_FFFF));
    void'(queue_op(rlsu_pkg::FUNC_REVERSE, 32'h1234_5678));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'hFFFF_FFFF));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_REVERSE, 32'h0));
    void'(queue_op(FUNC_UNUSED, 32'hDEAD_BEEF));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'h5555_5555));
    void'(queue_op(rlsu_pkg::FUNC_REVERSE, 32'h0));
    void'(queue_op(FUNC_UNUSED, 32'hFFFF_FFFF));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'hAAAA_AAAA));
    void'(queue_op(rlsu_pkg::FUNC_PUSH, 32'h0000_0001));
    void'(queue_op(rlsu_pkg::FUNC_REVERSE, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));
    void'(queue_op(rlsu_pkg::FUNC_POP, 32'h0));

    // Random sequences: fill up past full, drain past empty, or mix.
    counted = 0;
    mode = 0;
    while (counted < RANDOM_OPS) begin
      if (mode == 0) begin
        while (gen_count < DEPTH) begin
          if ($urandom_range(0, 9) < 8) eff = queue_op(rlsu_pkg::FUNC_PUSH, rand_word());
          else if ($urandom_range(0, 1)) eff = queue_op(rlsu_pkg::FUNC_POP, rand_word());
          else eff = queue_op(rlsu_pkg::FUNC_REVERSE, rand_word());
          counted += eff;
        end
        extra = $urandom_range(1, 4);
        repeat (extra) counted += queue_op(rlsu_pkg::FUNC_PUSH, rand_word());
        if ($urandom_range(0, 1)) counted += queue_op(rlsu_pkg::FUNC_REVERSE, rand_word());
      end else if (mode == 1) begin
        while (gen_count > 0) begin
          if ($urandom_range(0, 9) < 8) eff = queue_op(rlsu_pkg::FUNC_POP, rand_word());
          else if ($urandom_range(0, 1)) eff = queue_op(rlsu_pkg::FUNC_PUSH, rand_word());
          else eff = queue_op(rlsu_pkg::FUNC_REVERSE, rand_word());
          counted += eff;
        end
        extra = $urandom_range(1, 3);
        repeat (extra) void'(queue_op(rlsu_pkg::FUNC_POP, rand_word()));
      end else begin
        seg_len = $urandom_range(10, 40);
        repeat (seg_len) begin
          case ($urandom_range(0, 19))
            0, 1:    eff = queue_op(rlsu_pkg::FUNC_REVERSE, rand_word());
            2:       eff = queue_op(FUNC_UNUSED, rand_word());
            default: eff = queue_op($urandom_range(0, 1) ? rlsu_pkg::FUNC_PUSH
                                                          : rlsu_pkg::FUNC_POP,
                                    rand_word());
          endcase
          counted += eff;
        end
      end
      mode = $urandom_range(0, 2);
    end
    total_ops = pending_ops.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sent_cnt == total_ops);
    wait (status_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (status_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, status_q.size());
    end
    $display("Ran %0d operations: %0d pushes (%0d dropped when full), %0d pops, %0d reverses",
             sent_cnt, n_push, n_drop, n_pop, n_rev);
    $display("Reverses on a full stack: %0d, ignored operations: %0d, results checked: %0d",
             n_full_rev, n_ignored, recv_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
